[hw/rtl/assert_macros.svh]
// assertion macros used by the top-level rtl file of the heartbeat supervisor
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/shs_pkg.sv]
// types and constants of the sensor heartbeat supervisor
`timescale 1ns / 1ps

package shs_pkg;

  // default sizes
  localparam int unsigned DEF_CHANNELS    = 6;
  localparam int unsigned DEF_COUNT_WIDTH = 16;

  // fixed field widths
  localparam int unsigned CHAN_W    = 3;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned TIMEOUT_W = 16;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd10000;

  // item commands
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_REPORT = 2'd1,
    CMD_EVAL   = 2'd2,
    CMD_IDLE   = 2'd3
  } cmd_t;

  // report states; any other code leaves the leak bit as it is
  typedef logic [1:0] leak_state_t;
  localparam leak_state_t LEAK_DRY = 2'd0;
  localparam leak_state_t LEAK_WET = 2'd1;

  // valve driver commands
  typedef enum logic [1:0] {
    VALVE_NONE  = 2'd0,
    VALVE_CLOSE = 2'd1,
    VALVE_OPEN  = 2'd2
  } valve_cmd_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_ENABLED_MASK  = 1'b0,
    REG_TIMEOUT_TICKS = 1'b1
  } cfg_reg_t;

  // one input item as held in the input register
  typedef struct packed {
    cmd_t              cmd;
    logic [CHAN_W-1:0] channel;
    leak_state_t       leak_state;
    logic              valve_busy;
  } item_t;

endpackage

[hw/rtl/shs_counters.sv]
// per-channel silence counters with timeout detection
`timescale 1ns / 1ps

module shs_counters #(
  parameter int unsigned CHANNELS    = shs_pkg::DEF_CHANNELS,
  parameter int unsigned COUNT_WIDTH = shs_pkg::DEF_COUNT_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [CHANNELS-1:0]    advance,
  input  logic [CHANNELS-1:0]    clear,
  input  logic [COUNT_WIDTH-1:0] limit,
  output logic [CHANNELS-1:0]    expire
);

  import shs_pkg::*;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
    logic [COUNT_WIDTH-1:0] count;
    logic [COUNT_WIDTH-1:0] count_inc;

    // wrapping increment, timeout when it lands on the limit
    assign count_inc = count + COUNT_WIDTH'(1);
    assign expire[g] = advance[g] && (count_inc == limit);

    always_ff @(posedge clk) begin
      if (rst) begin
        count <= '0;
      end else if (clear[g] || expire[g]) begin
        count <= '0;
      end else if (advance[g]) begin
        count <= count_inc;
      end
    end
  end

endmodule

[hw/rtl/shs_ctrl.sv]
// supervisor state, single-pass item update and result register
`timescale 1ns / 1ps

module shs_ctrl #(
  parameter int unsigned CHANNELS    = shs_pkg::DEF_CHANNELS,
  parameter int unsigned COUNT_WIDTH = shs_pkg::DEF_COUNT_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [0:0]               cfg_addr,
  input  logic [shs_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                     item_valid,
  input  shs_pkg::item_t           item,
  output logic                     ready,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic [1:0]               valve_cmd,
  output logic                     valve_is_open,
  output logic                     alarm_on,
  output logic                     fault_tone,
  output logic [CHANNELS-1:0]      leak_flags,
  output logic [CHANNELS-1:0]      fault_flags
);

  import shs_pkg::*;

  // configuration
  logic [CHANNELS-1:0]  enabled_mask;
  logic [TIMEOUT_W-1:0] timeout_ticks;

  // supervisor state
  logic [CHANNELS-1:0] alive_mask, alive_mask_next;
  logic [CHANNELS-1:0] fault_mask, fault_mask_next;
  logic [CHANNELS-1:0] pending_mask, pending_mask_next;
  logic [CHANNELS-1:0] leak_mask, leak_mask_next;
  logic [CHANNELS-1:0] prev_leak, prev_leak_next;
  logic [CHANNELS-1:0] prev_fault, prev_fault_next;
  logic                valve_open, valve_open_next;
  logic                alarm_reg, alarm_reg_next;
  logic                tone_reg, tone_reg_next;
  valve_cmd_t          vcmd_next;

  logic                   take;
  logic                   is_tick, is_report, is_eval;
  logic                   eval_due, eval_run, eval_hold;
  logic                   chan_hit;
  logic [CHANNELS-1:0]    chan_bit;
  logic [CHANNELS-1:0]    advance, clear, expire;
  logic [COUNT_WIDTH-1:0] limit;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled_mask  <= '1;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ENABLED_MASK:  enabled_mask  <= cfg_wdata[CHANNELS-1:0];
        REG_TIMEOUT_TICKS: timeout_ticks <= cfg_wdata[TIMEOUT_W-1:0];
        default:           ;
      endcase
    end
  end

  // handshake: result register frees up when empty or taken
  assign ready = !out_valid || !out_stall;
  assign take  = item_valid && ready;

  // item decode
  assign is_tick   = take && (item.cmd == CMD_TICK);
  assign is_report = take && (item.cmd == CMD_REPORT);
  assign is_eval   = take && (item.cmd == CMD_EVAL);
  assign chan_hit  = 32'(item.channel) < CHANNELS;
  assign chan_bit  = chan_hit ? (CHANNELS'(1) << item.channel) : '0;
  assign eval_due  = (leak_mask != prev_leak) || (pending_mask != '0);
  assign eval_run  = is_eval && eval_due && !item.valve_busy;
  assign eval_hold = is_eval && eval_due && item.valve_busy;

  // counter controls
  assign advance = is_tick ? (enabled_mask & alive_mask) : '0;
  assign clear   = eval_run ? (enabled_mask & pending_mask) : '0;
  assign limit   = COUNT_WIDTH'(timeout_ticks);

  shs_counters #(
    .CHANNELS    (CHANNELS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_counters (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .clear   (clear),
    .limit   (limit),
    .expire  (expire)
  );

  // next state of one item
  always_comb begin
    alive_mask_next   = (alive_mask & ~expire) | clear;
    fault_mask_next   = (fault_mask | expire) & ~clear;
    pending_mask_next = pending_mask & ~clear;
    leak_mask_next    = leak_mask;
    prev_leak_next    = prev_leak;
    prev_fault_next   = prev_fault;
    valve_open_next   = valve_open;
    alarm_reg_next    = alarm_reg;
    tone_reg_next     = tone_reg;
    vcmd_next         = VALVE_NONE;

    // sensor report
    if (is_report) begin
      if (item.leak_state == LEAK_WET) begin
        leak_mask_next = leak_mask | chan_bit;
      end else if (item.leak_state == LEAK_DRY) begin
        leak_mask_next = leak_mask & ~chan_bit;
      end
      pending_mask_next = pending_mask | chan_bit;
    end

    // evaluate pass: valve and alarm from the leak mask
    if (eval_run) begin
      if (leak_mask == '0) begin
        if (valve_open) begin
          vcmd_next       = VALVE_CLOSE;
          valve_open_next = 1'b0;
        end
      end else begin
        if (!valve_open) begin
          vcmd_next       = VALVE_OPEN;
          valve_open_next = 1'b1;
        end
      end
      alarm_reg_next = |leak_mask;
      prev_leak_next = leak_mask;
    end

    // fault check, skipped while an evaluate waits on a busy valve
    if (take && !eval_hold && (fault_mask_next != prev_fault)) begin
      alarm_reg_next  = |fault_mask_next;
      tone_reg_next   = |fault_mask_next;
      prev_fault_next = fault_mask_next;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alive_mask   <= '1;
      fault_mask   <= '0;
      pending_mask <= '0;
      leak_mask    <= '0;
      prev_leak    <= '0;
      prev_fault   <= '0;
      valve_open   <= 1'b0;
      alarm_reg    <= 1'b0;
      tone_reg     <= 1'b0;
    end else begin
      alive_mask   <= alive_mask_next;
      fault_mask   <= fault_mask_next;
      pending_mask <= pending_mask_next;
      leak_mask    <= leak_mask_next;
      prev_leak    <= prev_leak_next;
      prev_fault   <= prev_fault_next;
      valve_open   <= valve_open_next;
      alarm_reg    <= alarm_reg_next;
      tone_reg     <= tone_reg_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      valve_cmd <= vcmd_next;
    end
  end

  // state only moves on a transfer, so it holds while the result is stalled
  assign valve_is_open = valve_open;
  assign alarm_on      = alarm_reg;
  assign fault_tone    = tone_reg;
  assign leak_flags    = leak_mask;
  assign fault_flags   = fault_mask;

endmodule

[hw/rtl/sensor_heartbeat_supervisor.sv]
// top level: input register, supervisor core and checks
// each item passes the input register, then the result register before it is offered
// throughput: one tick, report or evaluate item per cycle while the output is not stalled; counters update in parallel
// the input register stalls only while a result waits on a stalled output
// reset (rst, synchronous, active high) restores all masks, counters and config defaults
// no clearing pass after reset: items are taken from the first cycle
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sensor_heartbeat_supervisor #(
  parameter int unsigned CHANNELS    = shs_pkg::DEF_CHANNELS,
  parameter int unsigned COUNT_WIDTH = shs_pkg::DEF_COUNT_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_addr,
  input  logic [shs_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 cmd,
  input  logic [shs_pkg::CHAN_W-1:0] channel,
  input  logic [1:0]                 leak_state,
  input  logic                       valve_busy,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 valve_cmd,
  output logic                       valve_is_open,
  output logic                       alarm_on,
  output logic                       fault_tone,
  output logic [CHANNELS-1:0]        leak_flags,
  output logic [CHANNELS-1:0]        fault_flags
);

  import shs_pkg::*;

  logic  item_valid;
  item_t item;
  logic  ready;

  // input register
  assign in_stall = item_valid && !ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.cmd        <= cmd_t'(cmd);
      item.channel    <= channel;
      item.leak_state <= leak_state;
      item.valve_busy <= valve_busy;
    end
  end

  // supervisor core
  shs_ctrl #(
    .CHANNELS    (CHANNELS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .item_valid    (item_valid),
    .item          (item),
    .ready         (ready),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .valve_cmd     (valve_cmd),
    .valve_is_open (valve_is_open),
    .alarm_on      (alarm_on),
    .fault_tone    (fault_tone),
    .leak_flags    (leak_flags),
    .fault_flags   (fault_flags)
  );

  // checks
  `ASSERT_IMPL(a_open_with_leak, clk, rst, out_valid && valve_cmd == VALVE_OPEN, valve_is_open && leak_flags != '0, "valve opened without a leak bit")
  `ASSERT_IMPL(a_close_when_dry, clk, rst, out_valid && valve_cmd == VALVE_CLOSE, !valve_is_open && leak_flags == '0, "valve closed with a leak bit set")
  `ASSERT_IMPL(a_stall_cause, clk, rst, in_stall, item_valid && out_valid && out_stall, "input stalled without a stalled result")
  `ASSERT_NEXT(a_bubble_drains, clk, rst, out_valid && !out_stall && !item_valid, !out_valid, "result offered with no item behind it")

endmodule

[tb/testbench.sv]
// self-checking testbench of the sensor heartbeat supervisor
`timescale 1ns / 1ps

module testbench;
  import shs_pkg::*;

  localparam int NCH         = DEF_CHANNELS;
  localparam int CYCLE_LIMIT = 50000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 4;
  localparam int QUIET_TICKS = 40;

  // one result transfer as the block should present it
  typedef struct packed {
    valve_cmd_t       vcmd;
    logic             is_open;
    logic             alarm;
    logic             tone;
    logic [NCH-1:0]   leaks;
    logic [NCH-1:0]   faults;
  } status_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [0:0]           cfg_addr = REG_ENABLED_MASK;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           cmd = CMD_TICK;
  logic [CHAN_W-1:0]    channel = '0;
  logic [1:0]           leak_state = LEAK_DRY;
  logic                 valve_busy = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           valve_cmd;
  logic                 valve_is_open;
  logic                 alarm_on;
  logic                 fault_tone;
  logic [NCH-1:0]       leak_flags;
  logic [NCH-1:0]       fault_flags;

  // shared run control
  logic    no_idle = 1'b0;
  logic    hold_request = 1'b0;
  int      mismatch_count = 0;
  int      results_seen = 0;
  int      cycle_count = 0;
  status_t expected_status[$];

  // supervisor state as predicted
  logic [TIMEOUT_W-1:0] silence_count [NCH];
  logic [NCH-1:0]       alive, faulted, pending, leaks, last_leaks, last_faults;
  logic                 valve_open_m, alarm_m, tone_m;
  logic [NCH-1:0]       cfg_enabled;
  logic [TIMEOUT_W-1:0] cfg_timeout;

  sensor_heartbeat_supervisor u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .channel      (channel),
    .leak_state   (leak_state),
    .valve_busy   (valve_busy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .valve_cmd    (valve_cmd),
    .valve_is_open(valve_is_open),
    .alarm_on     (alarm_on),
    .fault_tone   (fault_tone),
    .leak_flags   (leak_flags),
    .fault_flags  (fault_flags)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // state after reset
  task automatic reset_supervisor_model();
    for (int i = 0; i < NCH; i++) silence_count[i] = '0;
    alive        = '1;
    faulted      = '0;
    pending      = '0;
    leaks        = '0;
    last_leaks   = '0;
    last_faults  = '0;
    valve_open_m = 1'b0;
    alarm_m      = 1'b0;
    tone_m       = 1'b0;
    cfg_enabled  = '1;
    cfg_timeout  = TIMEOUT_RESET;
  endtask

  // advance the predicted state by one item and return the status it leaves
  function automatic status_t predict_status(cmd_t c, logic [CHAN_W-1:0] ch,
                                             leak_state_t ls, logic busy);
    status_t    s;
    logic       fault_check;
    valve_cmd_t vc;
    fault_check = 1'b1;
    vc          = VALVE_NONE;
    case (c)
      CMD_TICK: begin
        for (int i = 0; i < NCH; i++) begin
          if (cfg_enabled[i] && alive[i]) begin
            silence_count[i] = silence_count[i] + 1'b1;
            if (silence_count[i] == cfg_timeout) begin
              silence_count[i] = '0;
              faulted[i]       = 1'b1;
              alive[i]         = 1'b0;
            end
          end
        end
      end
      CMD_REPORT: begin
        if (ch < NCH) begin
          if (ls == LEAK_WET) leaks[ch] = 1'b1;
          else if (ls == LEAK_DRY) leaks[ch] = 1'b0;
          pending[ch] = 1'b1;
        end
      end
      CMD_EVAL: begin
        if (leaks != last_leaks || pending != '0) begin
          if (busy) begin
            fault_check = 1'b0;
          end else begin
            for (int i = 0; i < NCH; i++) begin
              if (cfg_enabled[i] && pending[i]) begin
                silence_count[i] = '0;
                alive[i]         = 1'b1;
                faulted[i]       = 1'b0;
                pending[i]       = 1'b0;
              end
            end
            if (leaks == '0) begin
              if (valve_open_m) begin
                vc           = VALVE_CLOSE;
                valve_open_m = 1'b0;
              end
            end else if (!valve_open_m) begin
              vc           = VALVE_OPEN;
              valve_open_m = 1'b1;
            end
            alarm_m    = |leaks;
            last_leaks = leaks;
          end
        end
      end
      default: ;
    endcase
    // fault mask change drives alarm and tone
    if (fault_check && faulted != last_faults) begin
      alarm_m     = |faulted;
      tone_m      = |faulted;
      last_faults = faulted;
    end
    s.vcmd    = vc;
    s.is_open = valve_open_m;
    s.alarm   = alarm_m;
    s.tone    = tone_m;
    s.leaks   = leaks;
    s.faults  = faulted;
    return s;
  endfunction

  // offer one item, hold it until transferred, then predict its status
  task automatic send_item(cmd_t c, logic [CHAN_W-1:0] ch, leak_state_t ls, logic busy);
    while (!no_idle && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    channel    <= ch;
    leak_state <= ls;
    valve_busy <= busy;
    do @(posedge clk); while (in_stall);
    expected_status.push_back(predict_status(c, ch, ls, busy));
  endtask

  // stop offering and wait for every outstanding status plus the pipeline latency
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // write one configuration register while the block is idle
  task automatic write_register(cfg_reg_t idx, logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ENABLED_MASK:  cfg_enabled = value[NCH-1:0];
      REG_TIMEOUT_TICKS: cfg_timeout = value[TIMEOUT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // random item of any shape, out-of-range codes included
  task automatic send_noise_item();
    send_item(cmd_t'($urandom_range(3)), CHAN_W'($urandom_range(7)),
              leak_state_t'($urandom_range(3)), 1'($urandom_range(1)));
  endtask

  // report bursts closed by an evaluate, tick runs, lone evaluates and some noise
  task automatic send_random_traffic(int n);
    int sent;
    int r;
    int k;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(99);
      if (r < 35) begin
        k = $urandom_range(1, 6);
        repeat (k) send_item(CMD_TICK, CHAN_W'($urandom_range(7)),
                             leak_state_t'($urandom_range(3)), 1'($urandom_range(1)));
        sent += k;
      end else if (r < 70) begin
        k = $urandom_range(1, 3);
        repeat (k) send_item(CMD_REPORT, CHAN_W'($urandom_range(NCH - 1)),
                             ($urandom_range(9) < 8) ? leak_state_t'($urandom_range(1)) :
                                                       leak_state_t'($urandom_range(3)),
                             1'($urandom_range(1)));
        send_item(CMD_EVAL, CHAN_W'($urandom_range(7)), leak_state_t'($urandom_range(3)),
                  $urandom_range(9) < 2);
        sent += k + 1;
      end else if (r < 85) begin
        send_item(CMD_EVAL, CHAN_W'($urandom_range(7)), leak_state_t'($urandom_range(3)),
                  1'($urandom_range(1)));
        sent++;
      end else begin
        send_noise_item();
        sent++;
      end
    end
  endtask

  // default registers: quiet evaluate, busy valve, open and close
  task automatic test_reset_defaults();
    send_item(CMD_TICK, 3'd0, LEAK_DRY, 1'b0);
    send_item(CMD_EVAL, 3'd0, LEAK_DRY, 1'b0);
    send_item(CMD_REPORT, 3'd0, LEAK_WET, 1'b0);
    send_item(CMD_EVAL, 3'd0, LEAK_DRY, 1'b1);
    send_item(CMD_EVAL, 3'd0, LEAK_DRY, 1'b0);
    send_item(CMD_REPORT, 3'd0, LEAK_DRY, 1'b0);
    send_item(CMD_EVAL, 3'd0, LEAK_DRY, 1'b0);
    drain();
  endtask

  // unchanged leak codes, channels out of range, unknown command, shortest timeout
  task automatic test_command_corners();
    write_register(REG_TIMEOUT_TICKS, 16'd1);
    write_register(REG_ENABLED_MASK, 16'd63);
    send_item(CMD_REPORT, 3'd5, 2'd2, 1'b0);
    send_item(CMD_REPORT, 3'd6, LEAK_WET, 1'b0);
    send_item(CMD_REPORT, 3'd7, LEAK_WET, 1'b1);
    send_item(CMD_REPORT, 3'd3, 2'd3, 1'b0);
    send_item(CMD_IDLE, 3'd7, 2'd3, 1'b1);
    send_item(CMD_TICK, 3'd2, LEAK_WET, 1'b1);
    send_item(CMD_EVAL, 3'd4, LEAK_DRY, 1'b0);
    send_item(CMD_REPORT, 3'd1, LEAK_WET, 1'b0);
    send_item(CMD_EVAL, 3'd1, LEAK_DRY, 1'b0);
    drain();
  endtask

  // a pending bit of a disabled channel keeps evaluate acting
  task automatic test_disabled_channels();
    write_register(REG_ENABLED_MASK, 16'd0);
    write_register(REG_TIMEOUT_TICKS, 16'd65535);
    send_item(CMD_REPORT, 3'd2, LEAK_WET, 1'b0);
    send_item(CMD_EVAL, 3'd0, LEAK_DRY, 1'b0);
    send_item(CMD_EVAL, 3'd0, LEAK_DRY, 1'b0);
    send_item(CMD_TICK, 3'd0, LEAK_DRY, 1'b0);
    drain();
    write_register(REG_ENABLED_MASK, 16'd63);
  endtask

  // zero timeout: a run of ticks well short of a counter wrap flags nothing
  task automatic test_zero_timeout();
    write_register(REG_TIMEOUT_TICKS, 16'd0);
    for (int i = 0; i < NCH; i++) send_item(CMD_REPORT, CHAN_W'(i), LEAK_DRY, 1'b0);
    send_item(CMD_EVAL, 3'd0, LEAK_DRY, 1'b0);
    no_idle = 1'b1;
    repeat (QUIET_TICKS) send_item(CMD_TICK, CHAN_W'($urandom_range(7)),
                                   leak_state_t'($urandom_range(3)), 1'($urandom_range(1)));
    drain();
    no_idle = 1'b0;
  endtask

  // receiver holds off so the block fills, then the sender waits for all results
  task automatic test_backpressure();
    write_register(REG_TIMEOUT_TICKS, 16'd4);
    hold_request = 1'b1;
    no_idle      = 1'b1;
    send_random_traffic(40);
    no_idle = 1'b0;
    drain();
    send_random_traffic(20);
    drain();
  endtask

  // random traffic over several register settings
  task automatic test_random_traffic();
    write_register(REG_TIMEOUT_TICKS, 16'd1);
    write_register(REG_ENABLED_MASK, 16'd63);
    send_random_traffic(80);
    drain();
    write_register(REG_ENABLED_MASK, CFG_W'($urandom_range(63)));
    write_register(REG_TIMEOUT_TICKS, CFG_W'($urandom_range(2, 12)));
    send_random_traffic(80);
    drain();
    write_register(REG_ENABLED_MASK, 16'd21);
    write_register(REG_TIMEOUT_TICKS, 16'd65535);
    send_random_traffic(50);
    drain();
    write_register(REG_ENABLED_MASK, CFG_W'($urandom_range(63)));
    write_register(REG_TIMEOUT_TICKS, CFG_W'($urandom_range(1, 20)));
    send_random_traffic(80);
    drain();
  endtask

  // receiver: random stall, long hold-off on request
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(99) < 27);
    end
  end

  // mismatch reporting, first few in full
  task automatic check_field(string name, logic [NCH-1:0] want, logic [NCH-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("result %0d: %s expected %0h, got %0h", results_seen, name, want, got);
    end
  endtask

  // compare each result transfer with the oldest predicted status
  always @(posedge clk) begin
    status_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_status.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("result %0d: no status was predicted", results_seen);
      end else begin
        want = expected_status.pop_front();
        check_field("valve_cmd", want.vcmd, valve_cmd);
        check_field("valve_is_open", want.is_open, valve_is_open);
        check_field("alarm_on", want.alarm, alarm_on);
        check_field("fault_tone", want.tone, fault_tone);
        check_field("leak_flags", want.leaks, leak_flags);
        check_field("fault_flags", want.faults, fault_flags);
      end
      results_seen++;
    end
  end

  // run time guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cycle limit reached with %0d results outstanding", expected_status.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // test sequence
  initial begin
    reset_supervisor_model();
    rst <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_command_corners();
    test_disabled_channels();
    test_zero_timeout();
    test_backpressure();
    test_random_traffic();
    drain();
    if (mismatch_count == 0 && expected_status.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/shs_pkg.sv
hw/rtl/shs_counters.sv
hw/rtl/shs_ctrl.sv
hw/rtl/sensor_heartbeat_supervisor.sv
tb/testbench.sv
